// ===== rtl/ptpp_pkg.sv =====
// Shared types and constants for the planar tile pixel plotter.
package ptpp_pkg;

   // One tile row: low colour plane in the low byte, high plane in the high byte.
   localparam int unsigned WORD_W = 16;
   localparam int unsigned ROW_W = 3;

   // Configuration port.
   localparam int unsigned CSR_IDX_W = 3;
   localparam int unsigned CSR_DATA_W = 9;
   localparam logic [CSR_IDX_W-1:0] REG_WIDTH_TILES = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_HEIGHT_TILES = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_TILE_BASE = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_TILE_COUNT = 3'd3;

   // Access kinds.
   localparam logic KIND_READ = 1'b0;
   localparam logic KIND_WRITE = 1'b1;

   // Slot reduction by reciprocal multiplication.
   localparam int unsigned SUM_W = 10;
   localparam int unsigned MOD_SHIFT = 20;
   localparam int unsigned RECIP_W = 17;
   localparam int unsigned QPROD_W = SUM_W + RECIP_W;
   localparam int unsigned QUOT_W = QPROD_W - MOD_SHIFT;
   localparam int unsigned BACK_W = QUOT_W + 11;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_CALC,
      ST_OFFS,
      ST_RECIP,
      ST_MOD,
      ST_READ,
      ST_WB
   } state_type;

endpackage

// ===== rtl/ptpp_tile_ram.sv =====
// Tile row store: one write port and one registered read port.
module ptpp_tile_ram import ptpp_pkg::*; #(
   parameter int unsigned DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WORD_W-1:0]        wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WORD_W-1:0]        rd_data
);

   logic [WORD_W-1:0] mem [DEPTH];
   logic [WORD_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/planar_tile_pixel_plotter.sv =====
// Top level of the planar tile pixel plotter: control, address arithmetic and result register.
//
// The block reads or writes the two-bit colour of one pixel in a bitmap area that is held as
// 8x8 tiles of two bit planes, one 16-bit store word per tile row (low plane in the low byte,
// high plane in the high byte, leftmost pixel in bit 7). Row 0 of a request is the bottom row
// of the area. The tile slot is tile_base + width_tiles * tile_row + tile_col, taken modulo
// TILE_SLOTS. A request whose coordinates lie outside the area, or whose tile offset is not
// below tile_count, returns fault with colour zero and leaves the store untouched. Every
// request returns exactly one response; writes return colour zero. After reset the block
// sweeps the store to zero, one word a cycle, through all 8 * TILE_SLOTS words (2048 at the
// default); req_stall stays high during the sweep while csr writes are still taken. After
// that a request goes from acceptance to the response register through bounds check and row
// multiply, offset add, two multiply steps for the slot reduction (quotient estimate, then
// remainder), the store read, and the write-back of the modified row. One request is in
// flight at a time: the block takes the next only after the write-back. A stalled response
// holds the write-back until the response register frees up. The user must ensure that
// configuration registers are written only while no request is in flight; the block does not enforce it.
module planar_tile_pixel_plotter import ptpp_pkg::*; #(
   parameter int unsigned TILE_SLOTS = 256
) (
   input  logic                  clock,
   input  logic                  reset,
   // Request channel.
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_kind,
   input  logic [7:0]            req_px,
   input  logic [7:0]            req_py,
   input  logic [1:0]            req_colour_in,
   // Response channel.
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [1:0]            rsp_colour_out,
   output logic                  rsp_fault,
   // Configuration write channel.
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   localparam int unsigned DEPTH = TILE_SLOTS * 8;
   localparam int unsigned SLOT_W = $clog2(TILE_SLOTS);
   localparam int unsigned ADDR_W = SLOT_W + ROW_W;
   // Reciprocal of TILE_SLOTS, rounded up; exact quotients for sums below 1024.
   localparam logic [RECIP_W-1:0] MOD_RECIP =
      RECIP_W'(((1 << MOD_SHIFT) + TILE_SLOTS - 1) / TILE_SLOTS);

   // Configuration registers.
   logic [5:0] width_ff, height_ff;
   logic [7:0] base_ff;
   logic [8:0] count_ff;

   // Control.
   state_type state_ff, state_in;
   logic [ADDR_W-1:0] clr_ff, clr_in;
   logic accept, load_out, ram_wb_we, clearing;

   // Request and arithmetic registers.
   logic kind_ff;
   logic [7:0] px_ff, py_ff;
   logic [1:0] colour_ff;
   logic outside_ff, fault_ff;
   logic [2:0] row_ff;
   logic [11:0] prod_ff;
   logic [SUM_W-1:0] sum_ff;
   logic [QUOT_W-1:0] quot_ff;
   logic [ADDR_W-1:0] addr_ff;

   // Response register.
   logic rsp_valid_ff;
   logic [1:0] rsp_colour_ff;
   logic rsp_fault_ff;

   // Combinational arithmetic.
   logic [8:0] w_px, h_px, yf;
   logic outside_in;
   logic [11:0] prod_in;
   logic [12:0] offset;
   logic fault_in;
   logic [SUM_W-1:0] sum_in;
   logic [QPROD_W-1:0] qprod;
   logic [BACK_W-1:0] back;
   logic [BACK_W-1:0] rem_full;
   logic [SLOT_W-1:0] slot;
   logic [2:0] bit_pos;
   logic [WORD_W-1:0] rd_word, new_word;
   logic [1:0] read_colour;

   // Store port.
   logic ram_we, ram_re;
   logic [ADDR_W-1:0] ram_waddr;
   logic [WORD_W-1:0] ram_wdata;

   assign csr_ready = 1'b1;

   // Configuration writes; unknown indexes are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= 6'd1;
         height_ff <= 6'd1;
         base_ff <= 8'd0;
         count_ff <= 9'd1;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_WIDTH_TILES: width_ff <= csr_data[5:0];
            REG_HEIGHT_TILES: height_ff <= csr_data[5:0];
            REG_TILE_BASE: base_ff <= csr_data[7:0];
            REG_TILE_COUNT: count_ff <= csr_data;
            default: begin
            end
         endcase
      end
   end

   // State register and clear counter.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
      end
   end

   // Next state and handshake/store controls.
   always_comb begin
      state_in = state_ff;
      clr_in = clr_ff;
      req_stall = 1'b1;
      accept = 1'b0;
      load_out = 1'b0;
      ram_wb_we = 1'b0;
      ram_re = 1'b0;
      clearing = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            clearing = 1'b1;
            clr_in = clr_ff + ADDR_W'(1);
            if (clr_ff == ADDR_W'(DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               accept = 1'b1;
               state_in = ST_CALC;
            end
         end
         ST_CALC: state_in = ST_OFFS;
         ST_OFFS: state_in = ST_RECIP;
         ST_RECIP: state_in = ST_MOD;
         ST_MOD: state_in = ST_READ;
         ST_READ: begin
            ram_re = !fault_ff;
            state_in = ST_WB;
         end
         ST_WB: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               load_out = 1'b1;
               ram_wb_we = (kind_ff == KIND_WRITE) && !fault_ff;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Bounds check, row flip and the width times tile row product.
   always_comb begin
      w_px = {width_ff, 3'b000};
      h_px = {height_ff, 3'b000};
      outside_in = ({1'b0, px_ff} >= w_px) || ({1'b0, py_ff} >= h_px);
      yf = h_px - 9'd1 - {1'b0, py_ff};
      prod_in = 12'(width_ff) * 12'(yf[8:3]);
   end

   // Tile offset, allocation check and slot sum before reduction.
   always_comb begin
      offset = {1'b0, prod_ff} + 13'(px_ff[7:3]);
      fault_in = outside_ff || (offset >= 13'(count_ff));
      sum_in = SUM_W'(base_ff) + SUM_W'(offset[8:0]);
   end

   // Slot = sum mod TILE_SLOTS through the quotient estimate.
   always_comb begin
      qprod = QPROD_W'(sum_ff) * QPROD_W'(MOD_RECIP);
      back = BACK_W'(quot_ff) * BACK_W'(TILE_SLOTS);
      rem_full = BACK_W'(sum_ff) - back;
      slot = rem_full[SLOT_W-1:0];
   end

   // Pixel select and plane update on the row just read.
   always_comb begin
      bit_pos = ~px_ff[2:0];
      new_word = rd_word;
      new_word[{1'b0, bit_pos}] = colour_ff[0];
      new_word[{1'b1, bit_pos}] = colour_ff[1];
      read_colour = {rd_word[{1'b1, bit_pos}], rd_word[{1'b0, bit_pos}]};
   end

   // Datapath registers, loaded in the state that produces them.
   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff <= req_kind;
         px_ff <= req_px;
         py_ff <= req_py;
         colour_ff <= req_colour_in;
      end
      if (state_ff == ST_CALC) begin
         outside_ff <= outside_in;
         prod_ff <= prod_in;
         row_ff <= yf[2:0];
      end
      if (state_ff == ST_OFFS) begin
         fault_ff <= fault_in;
         sum_ff <= sum_in;
      end
      if (state_ff == ST_RECIP) begin
         quot_ff <= qprod[QPROD_W-1:MOD_SHIFT];
      end
      if (state_ff == ST_MOD) begin
         addr_ff <= {slot, row_ff};
      end
   end

   // Response register; it frees when the consumer takes it.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         rsp_fault_ff <= fault_ff;
         rsp_colour_ff <= (fault_ff || (kind_ff == KIND_WRITE)) ? 2'b00 : read_colour;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_colour_out = rsp_colour_ff;
   assign rsp_fault = rsp_fault_ff;

   // The clearing sweep and the write-back share the store's write port.
   assign ram_we = clearing || ram_wb_we;
   assign ram_waddr = clearing ? clr_ff : addr_ff;
   assign ram_wdata = clearing ? '0 : new_word;

   ptpp_tile_ram #(
      .DEPTH(DEPTH)
   ) u_ram (
      .clock(clock),
      .wr_en(ram_we),
      .wr_addr(ram_waddr),
      .wr_data(ram_wdata),
      .rd_en(ram_re),
      .rd_addr(addr_ff),
      .rd_data(rd_word)
   );

   // No request may enter while the store is being cleared.
   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> req_stall)
      else $error("request taken during store clear");

   // A faulting access never writes the store.
   a_no_write_on_fault: assert property (@(posedge clock) disable iff (reset)
      ram_wb_we |-> !fault_ff)
      else $error("store written on a faulting access");

   // Only one request in flight: acceptance stalls the channel in the next cycle.
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("second request taken while one is in flight");

   // A fault response carries colour zero.
   a_fault_colour: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_fault) |-> (rsp_colour_out == 2'b00))
      else $error("fault response with nonzero colour");

   // The response register is never overwritten while it is stalled.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |-> !load_out)
      else $error("stalled response overwritten");

endmodule
